// File: src/recent_message_dedup_cache_macros.svh
// Assertion macros for the dedup cache. Clock is clk, reset is rst.
`ifndef RECENT_MESSAGE_DEDUP_CACHE_MACROS_SVH
`define RECENT_MESSAGE_DEDUP_CACHE_MACROS_SVH

`ifndef SYNTHESIS
`define RMDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RMDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMDC_ASSERT(lbl, prop, msg)
`define RMDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/rmdc_pkg.sv
package rmdc_pkg;

  localparam int ID_W    = 64;
  localparam int NONCE_W = 32;
  localparam int KEY_W   = ID_W + NONCE_W;
  localparam int AGE_W   = 4;
  localparam int AGE_MAX = 15;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic shift;
    key_t key;
  } bcast_t;

  // Reduced match result.
  typedef struct packed {
    logic             hit;
    logic [AGE_W-1:0] age;
  } match_sum_t;

endpackage

// File: src/rmdc_if.sv
interface rmdc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] msg_id;
  logic [31:0] msg_nonce;

  modport source (output valid, req_type, msg_id, msg_nonce, input ready);
  modport sink   (input valid, req_type, msg_id, msg_nonce, output ready);
endinterface

interface rmdc_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [3:0] hit_age;
  logic       stored;
  logic       evicted;

  modport source (output valid, hit, hit_age, stored, evicted, input ready);
  modport sink   (input valid, hit, hit_age, stored, evicted, output ready);
endinterface

// File: src/rmdc_cell.sv
module rmdc_cell (
  input  logic            clk,
  input  logic            rst,
  input  rmdc_pkg::bcast_t bcast,
  input  rmdc_pkg::key_t  key_in,
  input  logic            valid_in,
  output rmdc_pkg::key_t  key,
  output logic            valid,
  output logic            match
);
  import rmdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      match <= valid && (key == bcast.key);
      if (bcast.shift) begin
        valid <= valid_in;
      end
    end
  end

  // key payload, no reset
  always_ff @(posedge clk) begin
    if (bcast.shift) begin
      key <= key_in;
    end
  end

endmodule

// File: src/rmdc_match_enc.sv
module rmdc_match_enc #(
  parameter int CAPACITY = 16
) (
  input  logic [CAPACITY-1:0]  match_vec,
  output rmdc_pkg::match_sum_t sum
);
  import rmdc_pkg::*;

  logic [AGE_W-1:0] age_acc;

  // At most one bit is set, so OR-ing the indices gives the age.
  always_comb begin
    age_acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        age_acc = age_acc | ((i > AGE_MAX) ? AGE_W'(AGE_MAX) : AGE_W'(i));
      end
    end
  end

  assign sum.hit = |match_vec;
  assign sum.age = age_acc;

endmodule

// File: src/recent_message_dedup_cache.sv
// Channel | Dir | Payload                          | Transfer
// req     | in  | req_type, msg_id, msg_nonce      | valid && ready
// rsp     | out | hit, hit_age, stored, evicted    | valid && ready
//
// Each request passes the steps capture, compare in all cells, decide/shift.
// The compare result is registered in each cell, so the next request waits
// until the table has shifted; a new request is taken only after decide retires the last.
// A finished result sits in the output register while the next request is
// taken; decide stalls only while that register is still full.
// rst (synchronous) clears all valid bits at once; keys are never cleared.
`include "recent_message_dedup_cache_macros.svh"

module recent_message_dedup_cache #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  rmdc_req_if.sink   req,
  rmdc_rsp_if.source rsp
);
  import rmdc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_DECIDE
  } state_t;

  state_t state;

  // captured request
  logic             req_insert;
  key_t             req_key;

  // cell chain
  bcast_t              bcast;
  key_t                cell_key   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] match_vec;
  match_sum_t          sum;

  // output register
  logic             out_valid;
  logic             out_hit;
  logic [AGE_W-1:0] out_age;
  logic             out_stored;
  logic             out_evicted;

  logic req_fire;
  logic dec_fire;
  logic do_shift;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // decide may retire only when the output register is free or being drained
  assign dec_fire  = (state == ST_DECIDE) && (!out_valid || rsp.ready);
  assign do_shift  = dec_fire && (req_insert == REQ_INSERT) && !sum.hit;

  assign bcast.shift = do_shift;
  assign bcast.key   = req_key;

  // Cell 0 takes the new key; every other cell takes its younger neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      rmdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .bcast    (bcast),
        .key_in   (req_key),
        .valid_in (1'b1),
        .key      (cell_key[g]),
        .valid    (cell_valid[g]),
        .match    (match_vec[g])
      );
    end else begin : g_body
      rmdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .bcast    (bcast),
        .key_in   (cell_key[g-1]),
        .valid_in (cell_valid[g-1]),
        .key      (cell_key[g]),
        .valid    (cell_valid[g]),
        .match    (match_vec[g])
      );
    end
  end

  rmdc_match_enc #(
    .CAPACITY (CAPACITY)
  ) u_enc (
    .match_vec (match_vec),
    .sum       (sum)
  );

  // request capture, payload only
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_insert <= req.req_type;
      req_key    <= {req.msg_id, req.msg_nonce};
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      out_hit     <= 1'b0;
      out_age     <= '0;
      out_stored  <= 1'b0;
      out_evicted <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            state <= ST_COMPARE;
          end
        end
        ST_COMPARE: begin
          // cells register their match flags this cycle
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (dec_fire) begin
            out_valid   <= 1'b1;
            out_hit     <= sum.hit;
            out_age     <= sum.hit ? sum.age : '0;
            out_stored  <= do_shift;
            out_evicted <= do_shift && cell_valid[CAPACITY-1];
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.hit     = out_hit;
  assign rsp.hit_age = out_age;
  assign rsp.stored  = out_stored;
  assign rsp.evicted = out_evicted;

  // checks
  `RMDC_ASSERT(a_single_match, (state == ST_DECIDE) |-> $onehot0(match_vec), "multiple matches")
  `RMDC_ASSERT(a_dec_result, dec_fire |=> (rsp.valid && (rsp.stored == $past(do_shift))), "result not loaded")
  `RMDC_ASSERT(a_head_write, do_shift |=> (cell_valid[0] && (cell_key[0] == $past(req_key))), "head cell not written")
  `RMDC_ASSERT_ALWAYS(a_reset_idle, rst |=> ((state == ST_IDLE) && !rsp.valid), "reset not clean")

endmodule

// File: tb/tb_top.sv
// Testbench for recent_message_dedup_cache.
//
// A local shadow of the key table predicts every response. Each request
// transfer pushes one predicted response onto result_fifo. The response
// monitor pops and compares each response transfer in order.
//
// Stimulus runs in two parts. A directed part covers the empty table, key
// extremes, duplicate insert, near-miss compare, fill, eviction and re-insert
// of an evicted key. Random traffic then runs in four flow-control phases:
// none, sender gaps, sink stalls, and both together. The random part mostly
// reuses a small key pool so hits, aging and evictions happen often.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmdc_pkg::*;

  localparam int DEPTH     = 16;   // DUT default CAPACITY
  localparam int POOL_SIZE = 24;   // larger than DEPTH so the table churns

  // Predicted response for one request.
  typedef struct {
    logic             hit;
    logic [AGE_W-1:0] hit_age;
    logic             stored;
    logic             evicted;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst;

  rmdc_req_if req_ch ();
  rmdc_rsp_if rsp_ch ();

  recent_message_dedup_cache #(.CAPACITY(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the table: slot 0 is newest.
  key_t          shadow_key   [DEPTH];
  logic          shadow_valid [DEPTH];
  cache_result_t result_fifo  [$];
  key_t          key_pool     [POOL_SIZE];

  int mismatch_count = 0;
  int send_idle_pct  = 0;   // chance, before each item, of a further sender gap cycle
  int sink_stall_pct = 0;   // chance per cycle of ready low on the response side

  // Compare against every valid slot. The youngest match wins. An insert
  // miss shifts the table older and writes the key at slot 0.
  function automatic cache_result_t lookup_and_update(logic is_insert, key_t key);
    cache_result_t r;
    r = '{hit: 1'b0, hit_age: '0, stored: 1'b0, evicted: 1'b0};
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == key) begin
        r.hit     = 1'b1;
        r.hit_age = (i > AGE_MAX) ? AGE_W'(AGE_MAX) : AGE_W'(i);
      end
    end
    if (is_insert == REQ_INSERT && !r.hit) begin
      r.evicted = shadow_valid[DEPTH-1];
      for (int i = DEPTH - 1; i > 0; i--) begin
        shadow_key[i]   = shadow_key[i-1];
        shadow_valid[i] = shadow_valid[i-1];
      end
      shadow_key[0]   = key;
      shadow_valid[0] = 1'b1;
      r.stored        = 1'b1;
    end
    return r;
  endfunction

  // Drives one request, with an optional sender gap first. The task waits for
  // the transfer and then records the prediction. valid stays high on return,
  // so back-to-back requests never drop it for a cycle.
  task automatic send_request(logic kind, logic [ID_W-1:0] id, logic [NONCE_W-1:0] nonce);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.msg_id    <= id;
    req_ch.msg_nonce <= nonce;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    result_fifo.push_back(lookup_and_update(kind, {id, nonce}));
  endtask

  // Response monitor. It also draws the sink-side ready at random. Values
  // read right after the edge are the ones the DUT sampled at that edge.
  always @(posedge clk) begin
    cache_result_t want;
    rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (result_fifo.size() == 0) begin
        $error("response transfer with no request outstanding");
        mismatch_count++;
      end else begin
        want = result_fifo.pop_front();
        if (rsp_ch.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
          mismatch_count++;
        end
        if (rsp_ch.hit_age !== want.hit_age) begin
          $error("hit_age: expected %0d, got %0d", want.hit_age, rsp_ch.hit_age);
          mismatch_count++;
        end
        if (rsp_ch.stored !== want.stored) begin
          $error("stored: expected %0d, got %0d", want.stored, rsp_ch.stored);
          mismatch_count++;
        end
        if (rsp_ch.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp_ch.evicted);
          mismatch_count++;
        end
      end
    end
  end

  // Empty table: every lookup misses. Unwritten slots are never read, because
  // every valid bit is clear.
  task automatic test_empty_lookup();
    send_request(REQ_LOOKUP, '1, '1);
  endtask

  // All-zero, all-one, mixed and checkerboard keys. Each must compare over the
  // full 96 bits.
  task automatic test_key_extremes();
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_INSERT, '0, '1);
    send_request(REQ_INSERT, '1, '0);
    send_request(REQ_INSERT, 64'hA5A5_5A5A_A5A5_5A5A, 32'h5A5A_A5A5);
    send_request(REQ_LOOKUP, '1, '1);                   // hit at age 3
  endtask

  // Inserting a key that is already present leaves the table alone. A key
  // that differs in one bit must miss.
  task automatic test_duplicate_insert();
    send_request(REQ_INSERT, '0, '0);                   // hit at age 4, no store
    send_request(REQ_LOOKUP, '1, 32'hFFFF_FFFE);        // near miss
  endtask

  // Fill to capacity, overflow, then check the oldest slot and the dropped
  // key. Re-inserting the dropped key causes one more eviction.
  task automatic test_fill_and_evict();
    for (int i = 0; i < DEPTH - 5; i++)
      send_request(REQ_INSERT, {48'h5EED_0000_0000, 16'(i)}, ~32'(i));
    send_request(REQ_INSERT, {48'h5EED_0000_0000, 16'hFFFF}, 32'h0);  // evicts 0/0
    send_request(REQ_LOOKUP, '1, '1);                   // oldest slot, age 15
    send_request(REQ_LOOKUP, '0, '0);                   // dropped, miss
    send_request(REQ_INSERT, '0, '0);                   // stored again, evicts
  endtask

  function automatic key_t random_key();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Random traffic, mostly on pooled keys so that hits happen at all ages.
  // The rest are single-bit near misses of pooled keys and fresh random keys.
  // Pool entries are replaced now and then, which keeps evictions going.
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    key_t k;
    int   pick;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < 5)
        key_pool[$urandom_range(POOL_SIZE-1)] = random_key();
      pick = $urandom_range(99);
      k    = key_pool[$urandom_range(POOL_SIZE-1)];
      if (pick >= 85)
        k = random_key();
      else if (pick >= 70)
        k = k ^ (key_t'(1) << $urandom_range(KEY_W-1));
      send_request($urandom_range(1) ? REQ_INSERT : REQ_LOOKUP,
                   k[KEY_W-1 -: ID_W], k[NONCE_W-1:0]);
    end
  endtask

  initial begin
    int guard;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_LOOKUP;
    req_ch.msg_id    <= '0;
    req_ch.msg_nonce <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_key[i]   = '0;
      shadow_valid[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = random_key();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_lookup();
    test_key_extremes();
    test_duplicate_insert();
    test_fill_and_evict();

    // Flow-control phases: none, sender gaps, sink stalls, both.
    test_random_traffic(440,  0,  0);
    test_random_traffic(440, 64,  0);
    test_random_traffic(440,  0, 64);
    test_random_traffic(440, 22, 22);

    // Drain with ready held high, then wait for stray responses.
    req_ch.valid   <= 1'b0;
    sink_stall_pct = 0;
    guard          = 0;
    while (result_fifo.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (result_fifo.size() != 0) begin
      $error("%0d responses never arrived", result_fifo.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rmdc_pkg.sv
src/rmdc_if.sv
src/rmdc_cell.sv
src/rmdc_match_enc.sv
src/recent_message_dedup_cache.sv
tb/tb_top.sv
